>>> src/modbus_tcp_rtu_frame_converter_assert.svh
// assertion macros used by the checker file
`ifndef MODBUS_TCP_RTU_FRAME_CONVERTER_ASSERT_SVH
`define MODBUS_TCP_RTU_FRAME_CONVERTER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define MBGW_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mbgw check failed: same-cycle rule");

// antecedent implies consequent in the next cycle
`define MBGW_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mbgw check failed: next-cycle rule");

`endif

>>> src/mbgw_pkg.sv
`timescale 1ns / 1ps

package mbgw_pkg;

   localparam int unsigned MAX_RESULTS = 7;
   localparam int unsigned CNT_W       = 3;

   // operation codes on the request channel
   localparam logic OP_REQUEST  = 1'b0;
   localparam logic OP_RESPONSE = 1'b1;

   // destination side of a result byte
   localparam logic SIDE_RTU = 1'b0;
   localparam logic SIDE_TCP = 1'b1;

   // crc-16/modbus
   localparam logic [15:0] CRC_INIT     = 16'hFFFF;
   localparam logic [15:0] CRC_POLY     = 16'hA001;
   localparam logic [15:0] CRC_SHR_MASK = 16'h7FFF;

   // mbap header byte positions
   localparam logic [2:0] POS_TID_HI = 3'd0;
   localparam logic [2:0] POS_TID_LO = 3'd1;
   localparam logic [2:0] POS_LEN_HI = 3'd4;
   localparam logic [2:0] POS_LEN_LO = 3'd5;
   localparam logic [2:0] HDR_BYTES  = 3'd6;

   localparam logic [7:0]  PROTO_ID_BYTE = 8'h00;
   localparam logic [15:0] RTU_CRC_BYTES = 16'd2;

   typedef struct packed {
      logic        op;
      logic [7:0]  data;
      logic        start;
      logic [15:0] rlen;
   } item_type;

   typedef struct packed {
      logic [7:0] data;
      logic       side;
      logic       fend;
   } rslt_type;

   typedef rslt_type [MAX_RESULTS-1:0] rslt_list_type;

   typedef struct packed {
      logic [15:0] crc;
      logic [2:0]  pos;
      logic [15:0] plen;
      logic [15:0] tid;
   } conv_state_type;

   // one byte of crc-16/modbus, eight reflected shift steps
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc_i, input logic [7:0] b);
      logic [15:0] c;
      c = crc_i ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = (c >> 1) & CRC_SHR_MASK;
         end
      end
      return c;
   endfunction

endpackage

>>> src/mbgw_xlate.sv
`timescale 1ns / 1ps

module mbgw_xlate (
   input  mbgw_pkg::conv_state_type         cur_state,
   input  mbgw_pkg::item_type               item,
   output mbgw_pkg::conv_state_type         nxt_state,
   output mbgw_pkg::rslt_list_type          rslt_list,
   output logic [mbgw_pkg::CNT_W-1:0]       rslt_cnt
);
   import mbgw_pkg::*;

   always_comb begin
      conv_state_type       st;
      rslt_list_type        lst;
      logic [CNT_W-1:0]     n;
      logic [15:0]          len;

      st  = cur_state;
      lst = '0;
      n   = '0;
      len = '0;

      if (item.op == OP_REQUEST) begin
         // new tcp frame restarts header count, payload count and crc
         if (item.start) begin
            st.pos  = '0;
            st.plen = '0;
            st.crc  = CRC_INIT;
         end
         if (st.pos < HDR_BYTES) begin
            // mbap header: keep transaction id and length
            case (st.pos)
               POS_TID_HI: st.tid[15:8]  = item.data;
               POS_TID_LO: st.tid[7:0]   = item.data;
               POS_LEN_HI: st.plen[15:8] = item.data;
               POS_LEN_LO: st.plen[7:0]  = item.data;
               default: ;
            endcase
            st.pos = st.pos + 3'd1;
            // empty message: crc of nothing follows the header
            if (st.pos == HDR_BYTES && st.plen == '0) begin
               lst[n] = '{data: st.crc[7:0], side: SIDE_RTU, fend: 1'b0};
               n = n + 3'd1;
               lst[n] = '{data: st.crc[15:8], side: SIDE_RTU, fend: 1'b1};
               n = n + 3'd1;
            end
         end else if (st.plen != '0) begin
            // payload byte: forward and fold into crc
            st.crc = crc16_byte(st.crc, item.data);
            lst[n] = '{data: item.data, side: SIDE_RTU, fend: 1'b0};
            n = n + 3'd1;
            st.plen = st.plen - 16'd1;
            if (st.plen == '0) begin
               lst[n] = '{data: st.crc[7:0], side: SIDE_RTU, fend: 1'b0};
               n = n + 3'd1;
               lst[n] = '{data: st.crc[15:8], side: SIDE_RTU, fend: 1'b1};
               n = n + 3'd1;
            end
         end
      end else begin
         // rtu frame start: emit mbap header toward tcp side
         if (item.start) begin
            len = (item.rlen >= RTU_CRC_BYTES) ? item.rlen - RTU_CRC_BYTES : '0;
            st.plen = len;
            st.pos  = HDR_BYTES;
            lst[n] = '{data: st.tid[15:8], side: SIDE_TCP, fend: 1'b0};
            n = n + 3'd1;
            lst[n] = '{data: st.tid[7:0], side: SIDE_TCP, fend: 1'b0};
            n = n + 3'd1;
            lst[n] = '{data: PROTO_ID_BYTE, side: SIDE_TCP, fend: 1'b0};
            n = n + 3'd1;
            lst[n] = '{data: PROTO_ID_BYTE, side: SIDE_TCP, fend: 1'b0};
            n = n + 3'd1;
            lst[n] = '{data: len[15:8], side: SIDE_TCP, fend: 1'b0};
            n = n + 3'd1;
            lst[n] = '{data: len[7:0], side: SIDE_TCP, fend: (len == '0)};
            n = n + 3'd1;
         end
         // forward rtu bytes until the crc tail
         if (st.plen != '0) begin
            st.plen = st.plen - 16'd1;
            lst[n] = '{data: item.data, side: SIDE_TCP, fend: (st.plen == '0)};
            n = n + 3'd1;
         end
      end

      nxt_state = st;
      rslt_list = lst;
      rslt_cnt  = n;
   end

endmodule

>>> src/modbus_tcp_rtu_frame_converter.sv
// Modbus TCP/RTU byte-stream gateway. Each request carries one frame byte:
// TCP request bytes (tuser bit 0 low) lose their 6-byte MBAP header and leave
// toward the RTU side with a CRC-16/Modbus appended, low byte first; RTU
// response bytes (tuser bit 0 high) gain an MBAP header built from the stored
// transaction ID and the given RTU length minus 2, and lose their CRC tail.
// A request is taken into an input register and converted into a result
// buffer of up to 7 bytes, which drains one byte per cycle on the rsp channel
// while rsp_tready is high; meanwhile the input register takes the next
// request and holds it until the buffer frees, unless it yields no byte.
// Sustained rate is one request per cycle while each request yields at most
// one byte and rsp_tready stays high; a request with more bytes holds the
// output until they drain. Results pass the input and buffer registers.
`timescale 1ns / 1ps

module modbus_tcp_rtu_frame_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] in_byte, [23:8] response_length
   input  logic [1:0]  req_tuser,   // [0] operation, [1] frame_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic [1:0]  rsp_tuser,   // [0] out_side, [1] last_of_run
   output logic        rsp_tlast    // frame_end
);
   import mbgw_pkg::*;

   logic             in_vld_ff, in_vld_in;
   item_type         in_item_ff, in_item_in;
   conv_state_type   st_ff, st_in;
   logic             bnd_vld_ff, bnd_vld_in;
   rslt_list_type    bnd_ff, bnd_in;
   logic [CNT_W-1:0] bnd_cnt_ff, bnd_cnt_in;
   logic [CNT_W-1:0] bnd_idx_ff, bnd_idx_in;

   conv_state_type   xl_state;
   rslt_list_type    xl_list;
   logic [CNT_W-1:0] xl_cnt;
   logic             bnd_last;
   logic             bnd_free;
   logic             advance;
   rslt_type         cur_rslt;

   // conversion of the held request against the frame state
   mbgw_xlate u_xlate (
      .cur_state (st_ff),
      .item      (in_item_ff),
      .nxt_state (xl_state),
      .rslt_list (xl_list),
      .rslt_cnt  (xl_cnt)
   );

   // handshake control
   assign bnd_last   = (bnd_idx_ff == bnd_cnt_ff - 3'd1);
   assign bnd_free   = !bnd_vld_ff || (bnd_last && rsp_tready);
   assign advance    = in_vld_ff && ((xl_cnt == '0) || bnd_free);
   assign req_tready = !in_vld_ff || advance;

   // input register
   always_comb begin
      in_vld_in  = in_vld_ff;
      in_item_in = in_item_ff;
      if (req_tvalid && req_tready) begin
         in_vld_in  = 1'b1;
         in_item_in = '{op: req_tuser[0], data: req_tdata[7:0],
                        start: req_tuser[1], rlen: req_tdata[23:8]};
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
   end

   // frame state moves when the held request is converted
   assign st_in = advance ? xl_state : st_ff;

   // result buffer load and drain
   always_comb begin
      bnd_vld_in = bnd_vld_ff;
      bnd_in     = bnd_ff;
      bnd_cnt_in = bnd_cnt_ff;
      bnd_idx_in = bnd_idx_ff;
      if (advance && xl_cnt != '0) begin
         bnd_vld_in = 1'b1;
         bnd_in     = xl_list;
         bnd_cnt_in = xl_cnt;
         bnd_idx_in = '0;
      end else if (bnd_vld_ff && rsp_tready) begin
         if (bnd_last) begin
            bnd_vld_in = 1'b0;
         end else begin
            bnd_idx_in = bnd_idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         bnd_vld_ff <= 1'b0;
         st_ff      <= '{crc: CRC_INIT, pos: '0, plen: '0, tid: '0};
      end else begin
         in_vld_ff  <= in_vld_in;
         bnd_vld_ff <= bnd_vld_in;
         st_ff      <= st_in;
      end
      in_item_ff <= in_item_in;
      bnd_ff     <= bnd_in;
      bnd_cnt_ff <= bnd_cnt_in;
      bnd_idx_ff <= bnd_idx_in;
   end

   // result outputs
   assign cur_rslt   = bnd_ff[bnd_idx_ff];
   assign rsp_tvalid = bnd_vld_ff;
   assign rsp_tdata  = cur_rslt.data;
   assign rsp_tuser  = {bnd_last, cur_rslt.side};
   assign rsp_tlast  = cur_rslt.fend;

endmodule

>>> src/mbgw_checker.sv
`timescale 1ns / 1ps
`include "modbus_tcp_rtu_frame_converter_assert.svh"

module mbgw_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   logic [10:0] rsp_word;
   logic        run_more;

   // whole result word and a taken byte that is not the last of its run
   assign rsp_word = {rsp_tdata, rsp_tuser, rsp_tlast};
   assign run_more = rsp_tvalid && rsp_tready && !rsp_tuser[1];

   // a stalled result holds still
   `MBGW_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_word))

   // a frame always ends on the last byte of a run
   `MBGW_ASSERT_SAME(a_end_is_run_last, rsp_tvalid && rsp_tlast, rsp_tuser[1])

   // a run continues at once and keeps its side
   `MBGW_ASSERT_NEXT(a_run_side, run_more, rsp_tvalid && (rsp_tuser[0] == $past(rsp_tuser[0])))

   // a byte that is not the last of its run never ends a frame
   `MBGW_ASSERT_NEXT(a_run_no_early_end, run_more, !$past(rsp_tlast))

endmodule

bind modbus_tcp_rtu_frame_converter mbgw_checker u_mbgw_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

>>> tb/modbus_tcp_rtu_frame_converter_tb.sv
`timescale 1ns / 1ps

module modbus_tcp_rtu_frame_converter_tb;
   import mbgw_pkg::*;

   // one converted byte as seen on the rsp channel
   typedef struct packed {
      logic [7:0] data;
      logic       side;
      logic       fend;
      logic       lrun;
   } gw_byte_type;

   localparam int RANDOM_ITEMS = 360;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   // stimulus and expected output
   item_type    pending_items [$];
   item_type    drive_item;
   gw_byte_type expected_bytes [$];

   int total_items = 1;
   int accepted_cnt = 0;
   int mismatch_cnt = 0;
   int send_idle_pct;
   int recv_stall_pct;

   // gateway state mirror
   logic [15:0] crc_acc = CRC_INIT;
   logic [15:0] hdr_pos = '0;
   logic [15:0] payload_left = '0;
   logic [15:0] trans_id = '0;

   modbus_tcp_rtu_frame_converter uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // reflected crc-16/modbus over one byte
   function automatic logic [15:0] crc16_update(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] c;
      c = acc ^ {8'h00, b};
      repeat (8) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : ((c >> 1) & CRC_SHR_MASK);
      end
      return c;
   endfunction

   // predict the bytes one request produces and queue them
   function automatic void convert_byte(input item_type it);
      gw_byte_type outs [MAX_RESULTS];
      int          n;
      logic [15:0] len;
      n = 0;
      if (it.op == OP_REQUEST) begin
         if (it.start) begin
            hdr_pos      = '0;
            payload_left = '0;
            crc_acc      = CRC_INIT;
         end
         if (hdr_pos < HDR_BYTES) begin
            case (hdr_pos)
               POS_TID_HI: trans_id[15:8] = it.data;
               POS_TID_LO: trans_id[7:0] = it.data;
               POS_LEN_HI: payload_left[15:8] = it.data;
               POS_LEN_LO: payload_left[7:0] = it.data;
               default: ;
            endcase
            hdr_pos++;
            // empty message: crc of nothing right after the header
            if (hdr_pos == HDR_BYTES && payload_left == 0) begin
               outs[n] = {crc_acc[7:0], SIDE_RTU, 1'b0, 1'b0};
               n++;
               outs[n] = {crc_acc[15:8], SIDE_RTU, 1'b1, 1'b0};
               n++;
            end
         end else if (payload_left > 0) begin
            crc_acc = crc16_update(crc_acc, it.data);
            outs[n] = {it.data, SIDE_RTU, 1'b0, 1'b0};
            n++;
            payload_left--;
            if (payload_left == 0) begin
               outs[n] = {crc_acc[7:0], SIDE_RTU, 1'b0, 1'b0};
               n++;
               outs[n] = {crc_acc[15:8], SIDE_RTU, 1'b1, 1'b0};
               n++;
            end
         end
      end else begin
         if (it.start) begin
            len          = (it.rlen >= RTU_CRC_BYTES) ? it.rlen - RTU_CRC_BYTES : 16'd0;
            payload_left = len;
            hdr_pos      = HDR_BYTES;
            outs[n] = {trans_id[15:8], SIDE_TCP, 1'b0, 1'b0};
            n++;
            outs[n] = {trans_id[7:0], SIDE_TCP, 1'b0, 1'b0};
            n++;
            outs[n] = {PROTO_ID_BYTE, SIDE_TCP, 1'b0, 1'b0};
            n++;
            outs[n] = {PROTO_ID_BYTE, SIDE_TCP, 1'b0, 1'b0};
            n++;
            outs[n] = {len[15:8], SIDE_TCP, 1'b0, 1'b0};
            n++;
            outs[n] = {len[7:0], SIDE_TCP, (len == 16'd0), 1'b0};
            n++;
         end
         if (payload_left > 0) begin
            payload_left--;
            outs[n] = {it.data, SIDE_TCP, (payload_left == 16'd0), 1'b0};
            n++;
         end
      end
      if (n > 0) begin
         outs[n-1].lrun = 1'b1;
      end
      for (int i = 0; i < n; i++) begin
         expected_bytes.push_back(outs[i]);
      end
   endfunction

   task automatic add_item(input logic op, input logic [7:0] data, input logic start,
                           input logic [15:0] rlen);
      item_type it;
      it.op    = op;
      it.data  = data;
      it.start = start;
      it.rlen  = rlen;
      pending_items.push_back(it);
   endtask

   // tcp request frame: mbap header, then npay random payload bytes
   task automatic add_tcp_frame(input logic start, input logic [15:0] tid,
                                input logic [15:0] proto, input logic [15:0] len,
                                input int npay);
      add_item(OP_REQUEST, tid[15:8], start, 16'($urandom));
      add_item(OP_REQUEST, tid[7:0], 1'b0, 16'($urandom));
      add_item(OP_REQUEST, proto[15:8], 1'b0, 16'($urandom));
      add_item(OP_REQUEST, proto[7:0], 1'b0, 16'($urandom));
      add_item(OP_REQUEST, len[15:8], 1'b0, 16'($urandom));
      add_item(OP_REQUEST, len[7:0], 1'b0, 16'($urandom));
      for (int i = 0; i < npay; i++) begin
         add_item(OP_REQUEST, 8'($urandom), 1'b0, 16'($urandom));
      end
   endtask

   // rtu response frame: first byte carries the length
   task automatic add_rtu_frame(input logic [15:0] rlen, input int nbytes);
      add_item(OP_RESPONSE, 8'($urandom), 1'b1, rlen);
      for (int i = 1; i < nbytes; i++) begin
         add_item(OP_RESPONSE, 8'($urandom), 1'b0, 16'($urandom));
      end
   endtask

   task automatic build_stimulus();
      int          pick;
      int          target;
      logic [15:0] len;
      // frame before any start flag, extreme header bytes
      add_tcp_frame(1'b0, 16'hFFFF, 16'h0000, 16'd2, 2);
      // zero-length request, crc goes out with the last header byte
      add_tcp_frame(1'b1, 16'h1234, 16'h0000, 16'd0, 0);
      // stray request byte after the frame is done
      add_item(OP_REQUEST, 8'hA5, 1'b0, 16'h0000);
      // short response, header only
      add_item(OP_RESPONSE, 8'h11, 1'b1, 16'h0000);
      // longest response length, full header plus byte
      add_item(OP_RESPONSE, 8'hFF, 1'b1, 16'hFFFF);
      // continuation byte without start
      add_item(OP_RESPONSE, 8'h00, 1'b0, 16'hFFFF);
      // request byte mixed into a running response count
      add_item(OP_REQUEST, 8'h5A, 1'b0, 16'h0000);
      // one-byte response payload ends with the header batch
      add_item(OP_RESPONSE, 8'h7E, 1'b1, 16'd3);
      // response byte once nothing remains
      add_item(OP_RESPONSE, 8'h42, 1'b0, 16'h0000);
      add_item(OP_RESPONSE, 8'h81, 1'b1, 16'd2);
      add_item(OP_RESPONSE, 8'h18, 1'b1, 16'd1);

      target = RANDOM_ITEMS;
      while (pending_items.size() < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            // mostly well-formed requests, some huge lengths cut short
            if ($urandom_range(0, 99) < 85) begin
               len = 16'($urandom_range(0, 8));
               add_tcp_frame($urandom_range(0, 19) != 0, 16'($urandom),
                             ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'h0000,
                             len, len);
            end else begin
               add_tcp_frame(1'b1, 16'($urandom), 16'($urandom), 16'($urandom),
                             $urandom_range(0, 6));
            end
         end else if (pick < 85) begin
            if ($urandom_range(0, 99) < 85) begin
               len = 16'($urandom_range(0, 10));
               add_rtu_frame(len, (len == 0) ? 1 : int'(len));
            end else begin
               add_rtu_frame(16'($urandom), $urandom_range(1, 6));
            end
         end else begin
            // noise
            repeat ($urandom_range(1, 3)) begin
               add_item(1'($urandom_range(0, 1)), 8'($urandom),
                        $urandom_range(0, 4) == 0, 16'($urandom));
            end
         end
      end
   endtask

   // idle profile follows progress through the item list
   always_comb begin
      if (accepted_cnt < total_items / 3) begin
         send_idle_pct  = 12;
         recv_stall_pct = 54;
      end else if (accepted_cnt < 2 * total_items / 3) begin
         send_idle_pct  = 54;
         recv_stall_pct = 12;
      end else begin
         send_idle_pct  = 0;
         recv_stall_pct = 0;
      end
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            convert_byte(drive_item);
            accepted_cnt <= accepted_cnt + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               drive_item = pending_items.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {drive_item.rlen, drive_item.data};
               req_tuser  <= {drive_item.start, drive_item.op};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // response monitor
   always @(posedge clock) begin
      gw_byte_type got;
      gw_byte_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata, rsp_tuser[0], rsp_tlast, rsp_tuser[1]};
         if (expected_bytes.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
               $display("unexpected byte: data=%h side=%b end=%b last=%b",
                        got.data, got.side, got.fend, got.lrun);
            end
         end else begin
            want = expected_bytes.pop_front();
            if (got !== want) begin
               mismatch_cnt++;
               if (mismatch_cnt <= 10) begin
                  $display("mismatch: exp data=%h side=%b end=%b last=%b",
                           want.data, want.side, want.fend, want.lrun);
                  $display("          got data=%h side=%b end=%b last=%b",
                           got.data, got.side, got.fend, got.lrun);
               end
            end
         end
      end
   end

   // sequencing and final verdict
   initial begin
      build_stimulus();
      total_items = pending_items.size();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      while (pending_items.size() > 0 || req_tvalid || expected_bytes.size() > 0) begin
         @(posedge clock);
      end
      repeat (30) @(posedge clock);
      if (mismatch_cnt == 0 && expected_bytes.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
